### src/gvb_pkg.sv
package gvb_pkg;

    // Datapath width of the shared unit and its adder.
    localparam int UnitW = 128;
    localparam int SumW  = UnitW + 2;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ATTRACT = 1'b1;

    localparam logic [7:0] REG_GRAV_CONST = 8'd0;
    localparam logic [7:0] REG_TIME_STEP  = 8'd1;

    typedef enum logic [4:0] {
        S_IDLE, S_SQX, S_SQY, S_DRT, S_GM, S_MAG, S_PX, S_CX, S_PY, S_CY,
        S_DT2, S_VX, S_VY, S_PVX, S_PAX, S_PVY, S_PAY, S_SPX, S_SPY, S_SPD, S_OUT
    } t_state;

    typedef enum logic [1:0] {UOP_MUL, UOP_DIV, UOP_SQRT} t_uop;

    function automatic logic signed [47:0] f_clamp48(input logic signed [63:0] v);
        logic signed [47:0] r;
        if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
            r = 48'sh7FFF_FFFF_FFFF;
        end else if (v < -64'sh0000_8000_0000_0000) begin
            r = 48'sh8000_0000_0000;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

    function automatic logic [46:0] f_sat47(input logic [UnitW-1:0] q);
        return (|q[UnitW-1:47]) ? '1 : q[46:0];
    endfunction

    // Clamp a product magnitude to 2^61 and apply the sign.
    function automatic logic signed [63:0] f_term(input logic [UnitW-1:0] m, input logic neg);
        logic [61:0] mm;
        logic signed [63:0] s;
        if ((|m[UnitW-1:62]) || (m[61] && (|m[60:0]))) begin
            mm = 62'h2000_0000_0000_0000;
        end else begin
            mm = m[61:0];
        end
        s = $signed({2'b00, mm});
        return neg ? -s : s;
    endfunction

    function automatic logic [47:0] f_abs48(input logic signed [47:0] v);
        return v[47] ? 48'(-v) : 48'(v);
    endfunction

    function automatic logic [48:0] f_abs49(input logic signed [48:0] v);
        return v[48] ? 49'(-v) : 49'(v);
    endfunction

    function automatic logic signed [63:0] f_sx48(input logic signed [47:0] v);
        return {{16{v[47]}}, v};
    endfunction

endpackage

### src/gravity_verlet_body_update_top.sv
// Channel     | Direction | Beat content
// ------------+-----------+--------------------------------------------------------
// s_axis      | in        | tdata pos_x,pos_y,vel_x,vel_y,mass; tuser cmd,is_self; tlast last
// m_axis      | out       | tdata pos_x,pos_y,vel_x,vel_y,speed; tuser zero_distance
// cfg         | in        | i_cfg_index selects grav_const (0) or time_step (1)
//
// One item runs as a chain of multiply, divide and square root steps on a single
// shared add/subtract unit that retires one bit (two radicand bits for roots) per cycle.
// A round-ending item also runs the Verlet step.
// Reset is synchronous and active low; it clears all body state and both registers.
// The input is not ready while an item is in flight; a finished result waits in the
// output register and does not block the next item from being accepted.
module gravity_verlet_body_update_top import gvb_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [223:0] s_axis_tdata,  // pos_x, pos_y, vel_x, vel_y, mass (low to high)
    input  logic [1:0]   s_axis_tuser,  // cmd, is_self (low to high)
    input  logic         s_axis_tlast,  // last
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [239:0] m_axis_tdata,  // out_pos_x, out_pos_y, out_vel_x, out_vel_y, speed
    output logic [0:0]   m_axis_tuser   // zero_distance
);

    // Configuration registers.
    logic [31:0] r_grav, r_dt;

    // Body state.
    logic signed [47:0] r_pos_x, r_pos_y, r_vel_x, r_vel_y;
    logic signed [47:0] r_acc_x, r_acc_y, r_pacc_x, r_pacc_y;

    // Per-item working registers.
    logic        r_last, r_zero, r_negx, r_negy;
    logic [48:0] r_ux, r_uy;
    logic [31:0] r_mass;
    logic [97:0] r_d2;
    logic [49:0] r_d;
    logic [46:0] r_mag;
    logic [63:0] r_dt2;
    logic [UnitW-1:0] r_tmp;
    logic signed [63:0] r_tp;
    logic [47:0] r_spd;

    // Sequencer.
    t_state r_state, n_state;
    logic   r_wait, n_wait;

    // Shared unit.
    t_uop             r_uop, u_op;
    logic [SumW-1:0]  r_uacc;
    logic [UnitW-1:0] r_dvs, r_shf, r_qot;
    logic [6:0]       r_cnt, u_n;
    logic             r_udone;
    logic             u_start;
    logic [UnitW-1:0] u_a, u_b;
    logic [SumW-1:0]  u_x, u_y;
    logic             u_sub;
    logic [SumW:0]    u_sum;
    logic             u_ok;

    logic cap;
    logic in_fire;
    logic [97:0] w_d2sum;
    logic signed [48:0] w_sx, w_sy, w_dx, w_dy;
    logic signed [47:0] w_in_px, w_in_py;

    // Output register.
    logic         r_o_valid;
    logic [239:0] r_o_data;
    logic         r_o_zero;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tuser  = r_o_zero;

    assign w_in_px = s_axis_tdata[47:0];
    assign w_in_py = s_axis_tdata[95:48];
    // Distance components are exact in 49 bits.
    assign w_dx = {w_in_px[47], w_in_px} - {r_pos_x[47], r_pos_x};
    assign w_dy = {w_in_py[47], w_in_py} - {r_pos_y[47], r_pos_y};
    assign w_sx = {r_pacc_x[47], r_pacc_x} + {r_acc_x[47], r_acc_x};
    assign w_sy = {r_pacc_y[47], r_pacc_y} + {r_acc_y[47], r_acc_y};
    assign w_d2sum = r_d2 + r_uacc[97:0];

    // The shared unit: one adder serves multiply (shift and add), restoring
    // division and digit-by-digit square root.
    always_comb begin
        u_x   = '0;
        u_y   = '0;
        u_sub = 1'b0;
        case (r_uop)
            UOP_MUL: begin
                u_x = {r_uacc[SumW-2:0], 1'b0};
                u_y = r_shf[UnitW-1] ? {2'b00, r_dvs} : '0;
            end
            UOP_DIV: begin
                u_x   = {r_uacc[SumW-2:0], r_shf[UnitW-1]};
                u_y   = {2'b00, r_dvs};
                u_sub = 1'b1;
            end
            default: begin
                u_x   = {r_uacc[SumW-3:0], r_shf[UnitW-1:UnitW-2]};
                u_y   = {r_qot, 2'b01};
                u_sub = 1'b1;
            end
        endcase
        u_sum = {1'b0, u_x} + {1'b0, (u_sub ? ~u_y : u_y)} + (SumW+1)'(u_sub);
        u_ok  = u_sum[SumW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_udone <= 1'b0;
            r_uop   <= UOP_MUL;
        end else begin
            r_udone <= 1'b0;
            if (u_start) begin
                r_uop  <= u_op;
                r_uacc <= '0;
                r_dvs  <= u_a;
                r_shf  <= u_b;
                r_qot  <= '0;
                r_cnt  <= u_n;
            end else if (r_cnt != '0) begin
                r_cnt   <= r_cnt - 7'd1;
                r_udone <= (r_cnt == 7'd1);
                case (r_uop)
                    UOP_MUL: begin
                        r_uacc <= u_sum[SumW-1:0];
                        r_shf  <= {r_shf[UnitW-2:0], 1'b0};
                    end
                    UOP_DIV: begin
                        r_uacc <= u_ok ? u_sum[SumW-1:0] : u_x;
                        r_qot  <= {r_qot[UnitW-2:0], u_ok};
                        r_shf  <= {r_shf[UnitW-2:0], 1'b0};
                    end
                    default: begin
                        r_uacc <= u_ok ? u_sum[SumW-1:0] : u_x;
                        r_qot  <= {r_qot[UnitW-2:0], u_ok};
                        r_shf  <= {r_shf[UnitW-3:0], 2'b00};
                    end
                endcase
            end
        end
    end

    // Sequencer: every compute state launches one unit step, waits for it and
    // then takes its result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
        end
    end

    always_comb begin
        n_state = r_state;
        n_wait  = r_wait;
        u_start = 1'b0;
        u_op    = UOP_MUL;
        u_a     = '0;
        u_b     = '0;
        u_n     = '0;
        cap     = 1'b0;
        if (r_state != S_IDLE && r_state != S_OUT) begin
            if (!r_wait) begin
                u_start = 1'b1;
                n_wait  = 1'b1;
            end else if (r_udone) begin
                cap    = 1'b1;
                n_wait = 1'b0;
            end
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (s_axis_tuser[0] == CMD_LOAD) begin
                        n_state = S_SPX;
                    end else if (s_axis_tuser[1]) begin
                        n_state = s_axis_tlast ? S_DT2 : S_SPX;
                    end else begin
                        n_state = S_SQX;
                    end
                end
            end
            S_SQX: begin
                u_a = UnitW'(r_ux);
                u_b = {r_ux, 79'd0};
                u_n = 7'd49;
                if (cap) n_state = S_SQY;
            end
            S_SQY: begin
                u_a = UnitW'(r_uy);
                u_b = {r_uy, 79'd0};
                u_n = 7'd49;
                if (cap) begin
                    if (w_d2sum == '0) n_state = r_last ? S_DT2 : S_SPX;
                    else n_state = S_DRT;
                end
            end
            S_DRT: begin
                u_op = UOP_SQRT;
                u_b  = {2'b00, r_d2, 28'd0};
                u_n  = 7'd50;
                if (cap) n_state = S_GM;
            end
            S_GM: begin
                u_a = UnitW'(r_grav);
                u_b = {r_mass, 96'd0};
                u_n = 7'd32;
                if (cap) n_state = S_MAG;
            end
            S_MAG: begin
                // Numerator is the 64-bit product shifted up by 40 bits.
                u_op = UOP_DIV;
                u_a  = UnitW'(r_d2);
                u_b  = {r_tmp[63:0], 64'd0};
                u_n  = 7'd104;
                if (cap) n_state = S_PX;
            end
            S_PX: begin
                u_a = UnitW'(r_mag);
                u_b = {r_ux, 79'd0};
                u_n = 7'd49;
                if (cap) n_state = S_CX;
            end
            S_CX: begin
                u_op = UOP_DIV;
                u_a  = UnitW'(r_d);
                u_b  = {r_tmp[95:0], 32'd0};
                u_n  = 7'd96;
                if (cap) n_state = S_PY;
            end
            S_PY: begin
                u_a = UnitW'(r_mag);
                u_b = {r_uy, 79'd0};
                u_n = 7'd49;
                if (cap) n_state = S_CY;
            end
            S_CY: begin
                u_op = UOP_DIV;
                u_a  = UnitW'(r_d);
                u_b  = {r_tmp[95:0], 32'd0};
                u_n  = 7'd96;
                if (cap) n_state = r_last ? S_DT2 : S_SPX;
            end
            S_DT2: begin
                u_a = UnitW'(r_dt);
                u_b = {r_dt, 96'd0};
                u_n = 7'd32;
                if (cap) n_state = S_VX;
            end
            S_VX: begin
                u_a = UnitW'(f_abs49(w_sx));
                u_b = {r_dt, 96'd0};
                u_n = 7'd32;
                if (cap) n_state = S_VY;
            end
            S_VY: begin
                u_a = UnitW'(f_abs49(w_sy));
                u_b = {r_dt, 96'd0};
                u_n = 7'd32;
                if (cap) n_state = S_PVX;
            end
            S_PVX: begin
                u_a = UnitW'(f_abs48(r_vel_x));
                u_b = {r_dt, 96'd0};
                u_n = 7'd32;
                if (cap) n_state = S_PAX;
            end
            S_PAX: begin
                u_a = UnitW'(f_abs48(r_acc_x));
                u_b = {r_dt2, 64'd0};
                u_n = 7'd64;
                if (cap) n_state = S_PVY;
            end
            S_PVY: begin
                u_a = UnitW'(f_abs48(r_vel_y));
                u_b = {r_dt, 96'd0};
                u_n = 7'd32;
                if (cap) n_state = S_PAY;
            end
            S_PAY: begin
                u_a = UnitW'(f_abs48(r_acc_y));
                u_b = {r_dt2, 64'd0};
                u_n = 7'd64;
                if (cap) n_state = S_SPX;
            end
            S_SPX: begin
                u_a = UnitW'(f_abs48(r_vel_x));
                u_b = {f_abs48(r_vel_x), 80'd0};
                u_n = 7'd48;
                if (cap) n_state = S_SPY;
            end
            S_SPY: begin
                u_a = UnitW'(f_abs48(r_vel_y));
                u_b = {f_abs48(r_vel_y), 80'd0};
                u_n = 7'd48;
                if (cap) n_state = S_SPD;
            end
            S_SPD: begin
                u_op = UOP_SQRT;
                u_b  = {2'b00, r_d2, 28'd0};
                u_n  = 7'd50;
                if (cap) n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_o_valid || m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Configuration writes and body state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav   <= '0;
            r_dt     <= '0;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_vel_x  <= '0;
            r_vel_y  <= '0;
            r_acc_x  <= '0;
            r_acc_y  <= '0;
            r_pacc_x <= '0;
            r_pacc_y <= '0;
            r_zero   <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_GRAV_CONST: r_grav <= i_cfg_data;
                    REG_TIME_STEP:  r_dt   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_fire) begin
                r_zero <= 1'b0;
                r_last <= s_axis_tlast;
                if (s_axis_tuser[0] == CMD_LOAD) begin
                    r_pos_x <= s_axis_tdata[47:0];
                    r_pos_y <= s_axis_tdata[95:48];
                    r_vel_x <= s_axis_tdata[143:96];
                    r_vel_y <= s_axis_tdata[191:144];
                end
            end
            if (cap) begin
                case (r_state)
                    S_SQY: if (w_d2sum == '0) r_zero <= 1'b1;
                    S_CX: r_acc_x <= f_clamp48(f_sx48(r_acc_x) +
                        (r_negx ? -$signed({17'd0, f_sat47(r_qot)})
                                : $signed({17'd0, f_sat47(r_qot)})));
                    S_CY: r_acc_y <= f_clamp48(f_sx48(r_acc_y) +
                        (r_negy ? -$signed({17'd0, f_sat47(r_qot)})
                                : $signed({17'd0, f_sat47(r_qot)})));
                    S_VX: r_vel_x <= f_clamp48(f_sx48(r_vel_x) +
                        f_term({17'd0, r_uacc[UnitW-1:17]}, w_sx[48]));
                    S_VY: r_vel_y <= f_clamp48(f_sx48(r_vel_y) +
                        f_term({17'd0, r_uacc[UnitW-1:17]}, w_sy[48]));
                    S_PAX: r_pos_x <= f_clamp48(f_sx48(r_pos_x) + r_tp +
                        f_term({33'd0, r_uacc[UnitW-1:33]}, r_acc_x[47]));
                    S_PAY: begin
                        r_pos_y  <= f_clamp48(f_sx48(r_pos_y) + r_tp +
                            f_term({33'd0, r_uacc[UnitW-1:33]}, r_acc_y[47]));
                        // The accumulated acceleration becomes the previous one.
                        r_pacc_x <= r_acc_x;
                        r_pacc_y <= r_acc_y;
                        r_acc_x  <= '0;
                        r_acc_y  <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // Working registers of one item.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ux   <= f_abs49(w_dx);
            r_uy   <= f_abs49(w_dy);
            r_negx <= w_dx[48];
            r_negy <= w_dy[48];
            r_mass <= s_axis_tdata[223:192];
        end
        if (cap) begin
            case (r_state)
                S_SQX, S_SPX: r_d2 <= r_uacc[97:0];
                S_SQY, S_SPY: r_d2 <= w_d2sum;
                S_DRT: r_d   <= r_qot[49:0];
                S_MAG: r_mag <= f_sat47(r_qot);
                S_GM, S_PX, S_PY: r_tmp <= r_uacc[UnitW-1:0];
                S_DT2: r_dt2 <= r_uacc[63:0];
                S_PVX, S_PVY: r_tp <= f_term({16'd0, r_uacc[UnitW-1:16]}, r_state == S_PVX ?
                                             r_vel_x[47] : r_vel_y[47]);
                S_SPD: r_spd <= r_qot[47:0];
                default: ;
            endcase
        end
    end

    // Output register, loaded when the previous result has gone.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_o_valid || m_axis_tready)) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
        if (r_state == S_OUT && (!r_o_valid || m_axis_tready)) begin
            r_o_data <= {r_spd, r_vel_y, r_vel_x, r_pos_y, r_pos_x};
            r_o_zero <= r_zero;
        end
    end

endmodule

### src/gvb_checker.sv
module gvb_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [239:0] m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    // An accepted item keeps the input closed for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after an accepted item");

    // No result can appear in the cycle after an item is taken.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result appeared one cycle after accept");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    // Reset leaves the block empty and ready.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("block not idle after reset");

endmodule

bind gravity_verlet_body_update_top gvb_checker u_gvb_checker (.*);
